// ===== rtl/qpt_pkg.sv =====
// Shared types, constants and the X4 transition decode for the quadrature pass tracker.
// No dependencies; imported by every module of the block.
package qpt_pkg;

   localparam int QPT_POS_WIDTH       = 16;
   localparam int QPT_CNT_WIDTH       = 16;
   localparam int QPT_QUEUE_DEPTH     = 4;
   localparam int QPT_FIELD_WIDTH     = 16;
   localparam int QPT_CSR_INDEX_WIDTH = 2;
   localparam int QPT_CSR_DATA_WIDTH  = 8;

   localparam logic [2:0] QPT_SCENARIO_RESET  = 3'd0;
   localparam logic [7:0] QPT_THRESHOLD_RESET = 8'd60;
   localparam logic [7:0] QPT_TOLERANCE_RESET = 8'd12;

   // effective scenario codes
   localparam logic [2:0] SCEN_USE_SWITCH = 3'd0;
   localparam logic [2:0] SCEN_BOTH_AUTH  = 3'd1;
   localparam logic [2:0] SCEN_A_AUTH     = 3'd2;
   localparam logic [2:0] SCEN_B_AUTH     = 3'd3;

   // clear_mask bit positions
   localparam int CLR_A_BIT      = 0;
   localparam int CLR_B_BIT      = 1;
   localparam int CLR_UNAUTH_BIT = 2;

   // lamp encoding, bit0 = cw, bit1 = ccw
   localparam logic [1:0] LAMP_OFF  = 2'b00;
   localparam logic [1:0] LAMP_CW   = 2'b01;
   localparam logic [1:0] LAMP_CCW  = 2'b10;
   localparam logic [1:0] LAMP_BOTH = 2'b11;

   typedef enum logic [1:0] {
      CSR_SCENARIO  = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_TOLERANCE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   typedef struct packed {
      logic [2:0] scenario_override;
      logic [7:0] pass_threshold;
      logic [7:0] reverse_tolerance;
   } qpt_csr_type;

   typedef struct packed {
      step_type   step;
      logic       home;
      logic       need_auth_a;
      logic       need_auth_b;
      logic [2:0] clear_mask;
   } qpt_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qpt_queue_status_type;

   // X4 decode of {previous A/B, new A/B}
   function automatic step_type qpt_step_decode(input logic [1:0] prev_ab,
                                                input logic [1:0] cur_ab);
      step_type result;
      case ({prev_ab, cur_ab})
         4'b0010, 4'b0100, 4'b1011, 4'b1101: result = STEP_UP;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: result = STEP_DOWN;
         default:                            result = STEP_NONE;
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/qpt_front.sv =====
// Front end: accepts A/B samples, decodes the X4 step and resolves authorization needs.
// Depends on qpt_pkg; feeds qpt_queue.
module qpt_front
   import qpt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  qpt_csr_type          csr,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_ab_state,
   input  logic                 req_index_level,
   input  logic [1:0]           req_switch_scenario,
   input  logic                 req_authorized_a,
   input  logic                 req_authorized_b,
   input  logic [2:0]           req_clear_mask,
   input  qpt_queue_status_type q_status,
   output logic                 push,
   output qpt_item_type         push_item
);

   logic [1:0] prev_ab_ff, prev_ab_in;
   logic [2:0] scenario;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      prev_ab_in = push ? req_ab_state : prev_ab_ff;
      if (csr.scenario_override != SCEN_USE_SWITCH) begin
         scenario = csr.scenario_override;
      end else begin
         scenario = {1'b0, req_switch_scenario} + 3'd1;
      end
      push_item.step        = qpt_step_decode(prev_ab_ff, req_ab_state);
      push_item.home        = req_index_level;
      push_item.need_auth_a = (scenario inside {SCEN_BOTH_AUTH, SCEN_A_AUTH}) && !req_authorized_a;
      push_item.need_auth_b = (scenario inside {SCEN_BOTH_AUTH, SCEN_B_AUTH}) && !req_authorized_b;
      push_item.clear_mask  = req_clear_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff <= 2'b00;
      end else begin
         prev_ab_ff <= prev_ab_in;
      end
   end

endmodule

// ===== rtl/qpt_queue.sv =====
// Short FIFO of decoded beats between the front and back ends.
// Depends on qpt_pkg for the entry and status types.
module qpt_queue
   import qpt_pkg::*;
#(
   parameter int DEPTH = QPT_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qpt_item_type         push_item,
   input  logic                 pop,
   output qpt_item_type         pop_item,
   output qpt_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qpt_item_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in     = count_ff + CNT_W'(push) - CNT_W'(pop);
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
      pop_item     = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== rtl/qpt_back.sv =====
// Back end: position, peak and reversal tracking, pass counting and the result register.
// Depends on qpt_pkg; drains qpt_queue.
module qpt_back
   import qpt_pkg::*;
#(
   parameter int POSITION_WIDTH = QPT_POS_WIDTH,
   parameter int COUNTER_WIDTH  = QPT_CNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  qpt_csr_type                       csr,
   input  qpt_queue_status_type              q_status,
   input  qpt_item_type                      q_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [QPT_FIELD_WIDTH-1:0] rsp_position,
   output logic signed [QPT_FIELD_WIDTH-1:0] rsp_peak_excursion,
   output logic                              rsp_led_cw,
   output logic                              rsp_led_ccw,
   output logic                              rsp_reversed,
   output logic                              rsp_pass_a_done,
   output logic                              rsp_pass_b_done,
   output logic                              rsp_unauthorized,
   output logic [QPT_FIELD_WIDTH-1:0]        rsp_count_a,
   output logic [QPT_FIELD_WIDTH-1:0]        rsp_count_b,
   output logic [QPT_FIELD_WIDTH-1:0]        rsp_count_unauth
);

   localparam int P = POSITION_WIDTH;
   localparam int C = COUNTER_WIDTH;
   localparam int F = QPT_FIELD_WIDTH;

   logic signed [P-1:0] pos_ff, pos_in, peak_ff, peak_in, next_pos;
   logic signed [P:0]   step_w, sum_w, pos_x, peak_x, diff_x;
   logic [P:0]          mag_pos, mag_peak, mag_diff;
   logic signed [P+1:0] peak_w, thr_w;
   logic                dir_ff, dir_in, rev_ff, rev_in;
   logic [1:0]          lamp_ff, lamp_in;
   logic [C-1:0]        cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in, cnt_u_ff, cnt_u_in;
   logic [C-1:0]        tot_a, tot_b, tot_u;
   logic                done_a, done_b, unauth, grow, rev_now;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [F-1:0] out_pos_ff, out_peak_ff;
   logic                out_cw_ff, out_ccw_ff, out_rev_ff;
   logic                out_pass_a_ff, out_pass_b_ff, out_unauth_ff;
   logic [F-1:0]        out_cnt_a_ff, out_cnt_b_ff, out_cnt_u_ff;

   always_comb begin
      pop          = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

      case (q_item.step)
         STEP_UP:   step_w = (P+1)'(1);
         STEP_DOWN: step_w = '1;
         default:   step_w = '0;
      endcase

      // saturating step
      sum_w = (P+1)'(pos_ff) + step_w;
      if (sum_w[P] != sum_w[P-1]) begin
         next_pos = sum_w[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
      end else begin
         next_pos = sum_w[P-1:0];
      end

      pos_x    = (P+1)'(next_pos);
      peak_x   = (P+1)'(peak_ff);
      diff_x   = peak_x - pos_x;
      mag_pos  = pos_x[P] ? -pos_x : pos_x;
      mag_peak = peak_x[P] ? -peak_x : peak_x;
      mag_diff = diff_x[P] ? -diff_x : diff_x;
      grow     = mag_peak < mag_pos;
      // a new peak sits on the position itself, so no backward travel then
      rev_now  = !grow && (mag_diff > (P+1)'(csr.reverse_tolerance));

      peak_w = (P+2)'(peak_ff);
      thr_w  = (P+2)'(csr.pass_threshold);

      pos_in  = pos_ff;
      peak_in = peak_ff;
      dir_in  = dir_ff;
      rev_in  = rev_ff;
      lamp_in = lamp_ff;
      done_a  = 1'b0;
      done_b  = 1'b0;
      unauth  = 1'b0;

      if (pop && q_item.step != STEP_NONE) begin
         if (q_item.home) begin
            if (!rev_ff) begin
               done_a = peak_w < -thr_w;
               done_b = peak_w > thr_w;
               unauth = (done_a && q_item.need_auth_a) || (done_b && q_item.need_auth_b);
            end
            pos_in  = '0;
            peak_in = '0;
            rev_in  = 1'b0;
            lamp_in = LAMP_OFF;
         end else begin
            peak_in = grow ? next_pos : peak_ff;
            dir_in  = grow ? (q_item.step == STEP_UP) : dir_ff;
            pos_in  = rev_now ? '0 : next_pos;
            rev_in  = rev_ff || rev_now;
            if (rev_in) begin
               lamp_in = LAMP_BOTH;
            end else if (dir_in) begin
               lamp_in = LAMP_CW;
            end else begin
               lamp_in = LAMP_CCW;
            end
         end
      end

      tot_a = cnt_a_ff + C'(done_a);
      tot_b = cnt_b_ff + C'(done_b);
      tot_u = cnt_u_ff + C'(unauth);

      // clear mask acts after the totals are reported
      cnt_a_in = (pop && q_item.clear_mask[CLR_A_BIT]) ? '0 : tot_a;
      cnt_b_in = (pop && q_item.clear_mask[CLR_B_BIT]) ? '0 : tot_b;
      cnt_u_in = (pop && q_item.clear_mask[CLR_UNAUTH_BIT]) ? '0 : tot_u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         peak_ff      <= '0;
         dir_ff       <= 1'b0;
         rev_ff       <= 1'b0;
         lamp_ff      <= LAMP_OFF;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         cnt_u_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         peak_ff      <= peak_in;
         dir_ff       <= dir_in;
         rev_ff       <= rev_in;
         lamp_ff      <= lamp_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cnt_u_ff     <= cnt_u_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_pos_ff    <= F'(pos_in);
         out_peak_ff   <= F'(peak_in);
         out_cw_ff     <= lamp_in[0];
         out_ccw_ff    <= lamp_in[1];
         out_rev_ff    <= rev_in;
         out_pass_a_ff <= done_a;
         out_pass_b_ff <= done_b;
         out_unauth_ff <= unauth;
         out_cnt_a_ff  <= F'(tot_a);
         out_cnt_b_ff  <= F'(tot_b);
         out_cnt_u_ff  <= F'(tot_u);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = out_pos_ff;
   assign rsp_peak_excursion = out_peak_ff;
   assign rsp_led_cw         = out_cw_ff;
   assign rsp_led_ccw        = out_ccw_ff;
   assign rsp_reversed       = out_rev_ff;
   assign rsp_pass_a_done    = out_pass_a_ff;
   assign rsp_pass_b_done    = out_pass_b_ff;
   assign rsp_unauthorized   = out_unauth_ff;
   assign rsp_count_a        = out_cnt_a_ff;
   assign rsp_count_b        = out_cnt_b_ff;
   assign rsp_count_unauth   = out_cnt_u_ff;

`ifndef SYNTHESIS
   a_rev_lamps: assert property (@(posedge clock) disable iff (reset)
      rev_ff |-> lamp_ff == LAMP_BOTH)
      else $error("reversal without both lamps on");
   a_home_clears: assert property (@(posedge clock) disable iff (reset)
      pop && q_item.step != STEP_NONE && q_item.home |=>
         pos_ff == '0 && peak_ff == '0 && !rev_ff && lamp_ff == LAMP_OFF)
      else $error("home step did not clear tracking state");
   a_one_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pass_a_done && rsp_pass_b_done))
      else $error("pass counted in both directions");
   a_unauth_needs_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unauthorized |-> rsp_pass_a_done || rsp_pass_b_done)
      else $error("unauthorized flagged without a pass");
`endif

endmodule

// ===== rtl/quadrature_pass_tracker.sv =====
// Path: an accepted sample is written into the queue, then popped into the result reg, and
// its result is on the rsp port from there; rsp_valid holds under rsp_stall until accepted.
// Throughput: one sample per cycle unless rsp_stall backs up the queue and raises req_stall.
// Reset (synchronous, active high): tracking state, totals and lamps zero, thresholds 60/12,
// scenario override 0. No clearing pass; req_stall is low right after reset.
// Depends on qpt_pkg, qpt_front, qpt_queue, qpt_back.
module quadrature_pass_tracker
   import qpt_pkg::*;
#(
   parameter int POSITION_WIDTH = QPT_POS_WIDTH,
   parameter int COUNTER_WIDTH  = QPT_CNT_WIDTH,
   parameter int QUEUE_DEPTH    = QPT_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [QPT_CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [QPT_CSR_DATA_WIDTH-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_ab_state,
   input  logic                                 req_index_level,
   input  logic [1:0]                           req_switch_scenario,
   input  logic                                 req_authorized_a,
   input  logic                                 req_authorized_b,
   input  logic [2:0]                           req_clear_mask,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [QPT_FIELD_WIDTH-1:0]    rsp_position,
   output logic signed [QPT_FIELD_WIDTH-1:0]    rsp_peak_excursion,
   output logic                                 rsp_led_cw,
   output logic                                 rsp_led_ccw,
   output logic                                 rsp_reversed,
   output logic                                 rsp_pass_a_done,
   output logic                                 rsp_pass_b_done,
   output logic                                 rsp_unauthorized,
   output logic [QPT_FIELD_WIDTH-1:0]           rsp_count_a,
   output logic [QPT_FIELD_WIDTH-1:0]           rsp_count_b,
   output logic [QPT_FIELD_WIDTH-1:0]           rsp_count_unauth
);

   qpt_csr_type          csr_ff, csr_in;
   qpt_queue_status_type q_status;
   qpt_item_type         push_item, pop_item;
   logic                 push, pop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCENARIO:  csr_in.scenario_override = csr_wdata[2:0];
            CSR_THRESHOLD: csr_in.pass_threshold    = csr_wdata;
            CSR_TOLERANCE: csr_in.reverse_tolerance = csr_wdata;
            default:       csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.scenario_override <= QPT_SCENARIO_RESET;
         csr_ff.pass_threshold    <= QPT_THRESHOLD_RESET;
         csr_ff.reverse_tolerance <= QPT_TOLERANCE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   qpt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr                 (csr_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_ab_state        (req_ab_state),
      .req_index_level     (req_index_level),
      .req_switch_scenario (req_switch_scenario),
      .req_authorized_a    (req_authorized_a),
      .req_authorized_b    (req_authorized_b),
      .req_clear_mask      (req_clear_mask),
      .q_status            (q_status),
      .push                (push),
      .push_item           (push_item)
   );

   qpt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   qpt_back #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .COUNTER_WIDTH  (COUNTER_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .q_status           (q_status),
      .q_item             (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position),
      .rsp_peak_excursion (rsp_peak_excursion),
      .rsp_led_cw         (rsp_led_cw),
      .rsp_led_ccw        (rsp_led_ccw),
      .rsp_reversed       (rsp_reversed),
      .rsp_pass_a_done    (rsp_pass_a_done),
      .rsp_pass_b_done    (rsp_pass_b_done),
      .rsp_unauthorized   (rsp_unauthorized),
      .rsp_count_a        (rsp_count_a),
      .rsp_count_b        (rsp_count_b),
      .rsp_count_unauth   (rsp_count_unauth)
   );

endmodule

// ===== dv/qpt_report_checker.sv =====
// Scoreboard for the quadrature pass tracker: predicts one report per accepted sample beat
// and checks every returned report field by field against the oldest prediction.
// Depends on qpt_pkg; watches the CSR write port to keep its own copy of the settings.
module qpt_report_checker
   import qpt_pkg::*;
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [QPT_CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [QPT_CSR_DATA_WIDTH-1:0]        csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [1:0]                           req_ab_state,
   input  logic                                 req_index_level,
   input  logic [1:0]                           req_switch_scenario,
   input  logic                                 req_authorized_a,
   input  logic                                 req_authorized_b,
   input  logic [2:0]                           req_clear_mask,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [QPT_FIELD_WIDTH-1:0]    rsp_position,
   input  logic signed [QPT_FIELD_WIDTH-1:0]    rsp_peak_excursion,
   input  logic                                 rsp_led_cw,
   input  logic                                 rsp_led_ccw,
   input  logic                                 rsp_reversed,
   input  logic                                 rsp_pass_a_done,
   input  logic                                 rsp_pass_b_done,
   input  logic                                 rsp_unauthorized,
   input  logic [QPT_FIELD_WIDTH-1:0]           rsp_count_a,
   input  logic [QPT_FIELD_WIDTH-1:0]           rsp_count_b,
   input  logic [QPT_FIELD_WIDTH-1:0]           rsp_count_unauth,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   reports_checked,
   output int                                   passes_a,
   output int                                   passes_b,
   output int                                   passes_unauth
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_MAX = 2 ** (QPT_POS_WIDTH - 1) - 1;
   localparam int POS_MIN = -POS_MAX - 1;

   typedef struct packed {
      logic signed [QPT_FIELD_WIDTH-1:0] position;
      logic signed [QPT_FIELD_WIDTH-1:0] peak_excursion;
      logic                              led_cw;
      logic                              led_ccw;
      logic                              reversed;
      logic                              pass_a_done;
      logic                              pass_b_done;
      logic                              unauthorized;
      logic [QPT_FIELD_WIDTH-1:0]        count_a;
      logic [QPT_FIELD_WIDTH-1:0]        count_b;
      logic [QPT_FIELD_WIDTH-1:0]        count_unauth;
   } pass_report_type;

   // settings copy
   logic [2:0]                        scen_reg;
   logic [7:0]                        threshold_reg;
   logic [7:0]                        tolerance_reg;

   // tracking state
   logic [1:0]                        last_ab;
   logic signed [QPT_POS_WIDTH-1:0]   pos_now;
   logic signed [QPT_POS_WIDTH-1:0]   peak_now;
   logic                              peak_rising;
   logic                              reversal_seen;
   logic [1:0]                        lamps;
   logic [QPT_CNT_WIDTH-1:0]          total_a;
   logic [QPT_CNT_WIDTH-1:0]          total_b;
   logic [QPT_CNT_WIDTH-1:0]          total_unauth;

   pass_report_type                   expected_reports[$];

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic track_sample(input logic [1:0] ab, input logic home, input logic [1:0] sw,
                               input logic auth_a, input logic auth_b, input logic [2:0] clr,
                               output pass_report_type rep);
      int   step;
      int   next_pos;
      int   scen_eff;
      logic hit_a;
      logic hit_b;
      logic no_auth;
      hit_a   = 1'b0;
      hit_b   = 1'b0;
      no_auth = 1'b0;
      case ({last_ab, ab})
         4'b0010, 4'b0100, 4'b1011, 4'b1101: step = 1;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: step = -1;
         default:                            step = 0;
      endcase
      last_ab = ab;
      if (step != 0) begin
         next_pos = int'(pos_now) + step;
         if (next_pos > POS_MAX) next_pos = POS_MAX;
         if (next_pos < POS_MIN) next_pos = POS_MIN;
         pos_now = QPT_POS_WIDTH'(next_pos);
         if (home) begin
            if (!reversal_seen) begin
               scen_eff = (scen_reg != SCEN_USE_SWITCH) ? int'(scen_reg) : int'(sw) + 1;
               if (int'(peak_now) < -int'(threshold_reg)) begin
                  hit_a   = 1'b1;
                  total_a = total_a + 1'b1;
                  if ((scen_eff == int'(SCEN_BOTH_AUTH) || scen_eff == int'(SCEN_A_AUTH))
                      && !auth_a) no_auth = 1'b1;
               end
               if (int'(peak_now) > int'(threshold_reg)) begin
                  hit_b   = 1'b1;
                  total_b = total_b + 1'b1;
                  if ((scen_eff == int'(SCEN_BOTH_AUTH) || scen_eff == int'(SCEN_B_AUTH))
                      && !auth_b) no_auth = 1'b1;
               end
               if (no_auth) total_unauth = total_unauth + 1'b1;
            end
            pos_now       = '0;
            peak_now      = '0;
            reversal_seen = 1'b0;
            lamps         = LAMP_OFF;
         end else begin
            if (magnitude(int'(peak_now)) < magnitude(int'(pos_now))) begin
               peak_now    = pos_now;
               peak_rising = (step > 0);
            end
            // backward travel from the peak past the tolerance drops the position to zero
            if (magnitude(int'(peak_now) - int'(pos_now)) > int'(tolerance_reg)) begin
               pos_now       = '0;
               reversal_seen = 1'b1;
            end
            if (reversal_seen)    lamps = LAMP_BOTH;
            else if (peak_rising) lamps = LAMP_CW;
            else                  lamps = LAMP_CCW;
         end
      end
      rep.position       = pos_now;
      rep.peak_excursion = peak_now;
      rep.led_cw         = lamps[0];
      rep.led_ccw        = lamps[1];
      rep.reversed       = reversal_seen;
      rep.pass_a_done    = hit_a;
      rep.pass_b_done    = hit_b;
      rep.unauthorized   = no_auth;
      rep.count_a        = total_a;
      rep.count_b        = total_b;
      rep.count_unauth   = total_unauth;
      // the report shows totals before the clear takes effect
      if (clr[CLR_A_BIT])      total_a      = '0;
      if (clr[CLR_B_BIT])      total_b      = '0;
      if (clr[CLR_UNAUTH_BIT]) total_unauth = '0;
      passes_a      += int'(hit_a);
      passes_b      += int'(hit_b);
      passes_unauth += int'(no_auth);
   endtask

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("report %0d: %s expected %h, got %h", reports_checked, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      pass_report_type want;
      pass_report_type got;
      if (reset) begin
         scen_reg        = QPT_SCENARIO_RESET;
         threshold_reg   = QPT_THRESHOLD_RESET;
         tolerance_reg   = QPT_TOLERANCE_RESET;
         last_ab         = '0;
         pos_now         = '0;
         peak_now        = '0;
         peak_rising     = 1'b0;
         reversal_seen   = 1'b0;
         lamps           = LAMP_OFF;
         total_a         = '0;
         total_b         = '0;
         total_unauth    = '0;
         mismatches      = 0;
         reports_checked = 0;
         passes_a        = 0;
         passes_b        = 0;
         passes_unauth   = 0;
         expected_reports.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCENARIO:  scen_reg      = csr_wdata[2:0];
               CSR_THRESHOLD: threshold_reg = csr_wdata;
               CSR_TOLERANCE: tolerance_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.position       = rsp_position;
            got.peak_excursion = rsp_peak_excursion;
            got.led_cw         = rsp_led_cw;
            got.led_ccw        = rsp_led_ccw;
            got.reversed       = rsp_reversed;
            got.pass_a_done    = rsp_pass_a_done;
            got.pass_b_done    = rsp_pass_b_done;
            got.unauthorized   = rsp_unauthorized;
            got.count_a        = rsp_count_a;
            got.count_b        = rsp_count_b;
            got.count_unauth   = rsp_count_unauth;
            if (expected_reports.size() == 0) begin
               if (mismatches < 10) $display("report beat with no sample waiting for it");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("position", want.position, got.position);
               compare_field("peak_excursion", want.peak_excursion, got.peak_excursion);
               compare_field("led_cw", 16'(want.led_cw), 16'(got.led_cw));
               compare_field("led_ccw", 16'(want.led_ccw), 16'(got.led_ccw));
               compare_field("reversed", 16'(want.reversed), 16'(got.reversed));
               compare_field("pass_a_done", 16'(want.pass_a_done), 16'(got.pass_a_done));
               compare_field("pass_b_done", 16'(want.pass_b_done), 16'(got.pass_b_done));
               compare_field("unauthorized", 16'(want.unauthorized), 16'(got.unauthorized));
               compare_field("count_a", want.count_a, got.count_a);
               compare_field("count_b", want.count_b, got.count_b);
               compare_field("count_unauth", want.count_unauth, got.count_unauth);
               reports_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            track_sample(req_ab_state, req_index_level, req_switch_scenario,
                         req_authorized_a, req_authorized_b, req_clear_mask, want);
            expected_reports.push_back(want);
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

// ===== dv/quadrature_pass_tracker_test.sv =====
// Top of the quadrature pass tracker testbench: clock, reset, sample and CSR stimulus,
// random report stalls and the verdict. Depends on qpt_pkg, the block and qpt_report_checker.
module quadrature_pass_tracker_test;
   import qpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_SAMPLES = 170;
   localparam int HOLD_CYCLES   = 80;

   typedef enum logic [1:0] {
      MOVE_UP,
      MOVE_DOWN,
      MOVE_HOLD,
      MOVE_JUMP
   } move_kind_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_wr_en;
   logic [QPT_CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [QPT_CSR_DATA_WIDTH-1:0]      csr_wdata;
   logic                               req_valid;
   logic                               req_stall;
   logic [1:0]                         req_ab_state;
   logic                               req_index_level;
   logic [1:0]                         req_switch_scenario;
   logic                               req_authorized_a;
   logic                               req_authorized_b;
   logic [2:0]                         req_clear_mask;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [QPT_FIELD_WIDTH-1:0]  rsp_position;
   logic signed [QPT_FIELD_WIDTH-1:0]  rsp_peak_excursion;
   logic                               rsp_led_cw;
   logic                               rsp_led_ccw;
   logic                               rsp_reversed;
   logic                               rsp_pass_a_done;
   logic                               rsp_pass_b_done;
   logic                               rsp_unauthorized;
   logic [QPT_FIELD_WIDTH-1:0]         rsp_count_a;
   logic [QPT_FIELD_WIDTH-1:0]         rsp_count_b;
   logic [QPT_FIELD_WIDTH-1:0]         rsp_count_unauth;

   int                                 mismatches;
   int                                 outstanding;
   int                                 reports_checked;
   int                                 passes_a;
   int                                 passes_b;
   int                                 passes_unauth;

   int                                 samples_sent = 0;
   int                                 settings_used = 0;
   logic [1:0]                         cur_ab = 2'd0;
   logic [7:0]                         cur_threshold = QPT_THRESHOLD_RESET;
   bit                                 idle_enable = 1'b0;
   bit                                 hold_request = 1'b0;

   // 0xFD: scenario 5 with junk in the unused upper bits
   logic [7:0] scen_set [8] = '{8'(SCEN_USE_SWITCH), 8'(SCEN_BOTH_AUTH), 8'(SCEN_A_AUTH),
                                8'(SCEN_B_AUTH), 8'd4, 8'hFD, 8'd6, 8'd7};
   logic [7:0] thr_set [8]  = '{8'd60, 8'd1, 8'd255, 8'd5, 8'd10, 8'd20, 8'd3, 8'd8};
   logic [7:0] tol_set [8]  = '{8'd12, 8'd1, 8'd255, 8'd3, 8'd8, 8'd255, 8'd1, 8'd4};

   quadrature_pass_tracker dut (.*);

   qpt_report_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(200us);
      $display("FAIL");
      $finish;
   end

   // report side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = idle_enable && ($urandom_range(99) < 18);
      end
   end

   function automatic logic [2:0] pick_clear();
      return ($urandom_range(99) < 12) ? 3'($urandom_range(7)) : 3'd0;
   endfunction

   // one sample beat; returns at the falling edge after it was taken
   task automatic move(input move_kind_type mv, input logic home, input logic [1:0] sw,
                       input logic auth_a, input logic auth_b, input logic [2:0] clr);
      logic [1:0] ab;
      while (idle_enable && $urandom_range(99) < 18) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      case (mv)
         MOVE_UP: begin
            case (cur_ab)
               2'd0:    ab = 2'd2;
               2'd2:    ab = 2'd3;
               2'd3:    ab = 2'd1;
               default: ab = 2'd0;
            endcase
         end
         MOVE_DOWN: begin
            case (cur_ab)
               2'd0:    ab = 2'd1;
               2'd1:    ab = 2'd3;
               2'd3:    ab = 2'd2;
               default: ab = 2'd0;
            endcase
         end
         MOVE_HOLD: ab = cur_ab;
         default:   ab = ~cur_ab;   // both pins flip: no step
      endcase
      req_ab_state        = ab;
      req_index_level     = home;
      req_switch_scenario = sw;
      req_authorized_a    = auth_a;
      req_authorized_b    = auth_b;
      req_clear_mask      = clr;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      cur_ab = ab;
      samples_sent++;
   endtask

   task automatic drift(input move_kind_type mv, input logic home);
      move(mv, home, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
           pick_clear());
   endtask

   // away from home for span steps with some backward jitter, then one step at home
   task automatic walk_pass(input logic toward_b, input int span, input int jitter_pct);
      move_kind_type ahead;
      move_kind_type back;
      int            r;
      ahead = toward_b ? MOVE_UP : MOVE_DOWN;
      back  = toward_b ? MOVE_DOWN : MOVE_UP;
      for (int i = 0; i < span; i++) begin
         r = int'($urandom_range(99));
         if (r < 3) drift($urandom_range(1) ? MOVE_HOLD : MOVE_JUMP, 1'b0);
         else       drift((r < 3 + jitter_pct) ? back : ahead, 1'b0);
      end
      drift($urandom_range(1) ? MOVE_UP : MOVE_DOWN, 1'b1);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
   endtask

   // settings change only with the block drained
   task automatic retune(input logic [7:0] scen, input logic [7:0] thr, input logic [7:0] tol);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      write_reg(CSR_SCENARIO, scen);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_TOLERANCE, tol);
      csr_wr_en     = 1'b0;
      cur_threshold = thr;
      settings_used++;
   endtask

   initial begin : stimulus
      int first;
      int span;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_SCENARIO;
      csr_wdata           = '0;
      req_valid           = 1'b0;
      req_ab_state        = 2'd0;
      req_index_level     = 1'b0;
      req_switch_scenario = 2'd0;
      req_authorized_a    = 1'b0;
      req_authorized_b    = 1'b0;
      req_clear_mask      = 3'd0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // reset settings: no-step beats and a short trip that cannot count
      move(MOVE_HOLD, 1'b1, 2'd3, 1'b1, 1'b1, 3'd7);
      move(MOVE_JUMP, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      move(MOVE_UP, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      move(MOVE_DOWN, 1'b1, 2'd1, 1'b0, 1'b1, 3'd0);

      retune(8'(SCEN_USE_SWITCH), 8'd2, 8'd2);
      // reversal: the trip back past the tolerance voids the pass
      repeat (3) move(MOVE_UP, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      repeat (4) move(MOVE_DOWN, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      move(MOVE_UP, 1'b1, 2'd0, 1'b1, 1'b1, 3'd0);
      // B pass under scenario 1 without authorization
      repeat (3) move(MOVE_UP, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      move(MOVE_UP, 1'b1, 2'd0, 1'b1, 1'b0, 3'd0);
      // A pass under scenario 3, where A needs none
      repeat (3) move(MOVE_DOWN, 1'b0, 2'd0, 1'b0, 1'b0, 3'd0);
      move(MOVE_DOWN, 1'b1, 2'd2, 1'b0, 1'b1, 3'd7);
      move(MOVE_UP, 1'b1, 2'd1, 1'b0, 1'b0, 3'd2);

      for (int phase = 0; phase < 8; phase++) begin
         retune(scen_set[phase], thr_set[phase], tol_set[phase]);
         idle_enable = (phase != 0);
         if (phase == 2) hold_request = 1'b1;
         first = samples_sent;
         while (samples_sent - first < PHASE_SAMPLES) begin
            if ($urandom_range(99) < 70) begin
               span = int'(cur_threshold) + int'($urandom_range(1, 12));
               if ($urandom_range(99) < 25) span = int'($urandom_range(1, cur_threshold + 1));
               walk_pass(1'($urandom_range(1)), span,
                         $urandom_range(1) ? 0 : int'($urandom_range(1, 15)));
            end else begin
               repeat ($urandom_range(1, 6))
                  drift(move_kind_type'($urandom_range(3)), 1'($urandom_range(1)));
            end
         end
      end

      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      $display("Ran %0d sample beats under %0d register settings, %0d reports checked.",
               samples_sent, settings_used, reports_checked);
      $display("Passes: %0d A, %0d B, %0d unauthorized, with reversals, clears and overrides.",
               passes_a, passes_b, passes_unauth);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
